// ===== sv/sha512_pkg.sv =====
// Shared types, constants and round functions of the SHA-512/384 engine.
`default_nettype none
package sha512_pkg;

	localparam int unsigned WORDS = 8;
	localparam int unsigned ROUNDS = 80;
	localparam int unsigned BLOCK_BYTES = 128;
	localparam int unsigned LEN_OFFSET = 112;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [1:0] {
		MODE_512 = 2'd0,
		MODE_384 = 2'd1,
		MODE_BAD = 2'd2,
		MODE_RSV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PAD,
		ST_COMP,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take_byte;
		logic write_pad;
		logic comp_start;
		logic comp_step;
		logic comp_finish;
		logic restart;
		logic emit_load;
		logic emit_next;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [6:0] fill;
		logic [6:0] round;
		logic       round_last;
	} stat_t;

	typedef logic [63:0] word_t;

	function automatic word_t ror(input word_t x, input int unsigned n);
		ror = (x >> n) | (x << (64 - n));
	endfunction

	function automatic word_t round_k(input logic [6:0] i);
		word_t k [0:79];
		k = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
		round_k = (i < 7'd80) ? k[i] : '0;
	endfunction

	function automatic word_t init_value(input logic [1:0] mode, input logic [2:0] i);
		word_t v512 [0:7];
		word_t v384 [0:7];
		v512 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
			64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
			64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
		v384 = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
			64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
			64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
		case (mode)
			MODE_512: init_value = v512[i];
			MODE_384: init_value = v384[i];
			default:  init_value = '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== sv/sha512_ctrl.sv =====
// Controller state machine: collect, pad, compress and emit sequencing.
`default_nettype none
module sha512_ctrl
	import sha512_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] mode,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_byte_valid,
	input  wire logic       in_eom,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic            out_last,
	output cmd_t            cmd,
	output logic            pad_extra,
	input  wire stat_t      stat
);

	state_t state_q, state_nx;
	logic   close_q;      // message end pending after current compression
	logic   pad_done_q;   // length block already written
	logic   pad_extra_q;  // padding spilled: second block needed
	logic [2:0] emit_idx_q;
	logic       accept;
	logic       full_after;
	logic [2:0] nwords;
	logic       has_words;

	assign accept = in_valid && in_ready;
	assign full_after = in_byte_valid && (stat.fill == 7'd127);
	assign nwords = (mode == MODE_384) ? 3'd5 : 3'd7;
	assign has_words = (mode == MODE_512) || (mode == MODE_384);
	assign out_last = (emit_idx_q == nwords);
	assign pad_extra = pad_extra_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (accept && full_after) state_nx = ST_COMP;
				else if (accept && in_eom) state_nx = ST_PAD;
			end
			ST_PAD: state_nx = ST_COMP;
			ST_COMP: begin
				if (stat.round_last) begin
					if (!close_q) state_nx = ST_COLLECT;
					else if (pad_done_q) state_nx = has_words ? ST_EMIT : ST_COLLECT;
					else state_nx = ST_PAD;
				end
			end
			ST_EMIT: if (out_ready && out_last) state_nx = ST_COLLECT;
			default: state_nx = ST_COLLECT;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_COLLECT) && !cfg_we;
		out_valid = (state_q == ST_EMIT);
		case (state_q)
			ST_COLLECT: begin
				cmd.take_byte = accept && in_byte_valid;
				cmd.comp_start = accept && full_after;
			end
			ST_PAD: begin
				cmd.write_pad = 1'b1;
				cmd.comp_start = 1'b1;
			end
			ST_COMP: begin
				cmd.comp_step = 1'b1;
				cmd.comp_finish = stat.round_last;
				cmd.emit_load = stat.round_last && close_q && pad_done_q;
				cmd.restart = stat.round_last && close_q && pad_done_q && !has_words;
			end
			ST_EMIT: begin
				cmd.emit_next = out_ready;
				cmd.restart = out_ready && out_last;
			end
			default: ;
		endcase
		if (cfg_we) cmd.restart = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			close_q <= 1'b0;
			pad_done_q <= 1'b0;
			pad_extra_q <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept && in_eom) close_q <= 1'b1;
			if (state_q == ST_PAD) begin
				// spill when fewer than 16 bytes remain after the marker
				if (!pad_extra_q && stat.fill >= 7'(LEN_OFFSET)) begin
					pad_extra_q <= 1'b1;
				end else begin
					pad_done_q <= 1'b1;
				end
			end
			if (cmd.emit_load) emit_idx_q <= '0;
			else if (cmd.emit_next) emit_idx_q <= emit_idx_q + 3'd1;
			if (state_nx == ST_COLLECT && state_q != ST_COLLECT && close_q
				&& (state_q == ST_EMIT || pad_done_q)) begin
				close_q <= 1'b0;
				pad_done_q <= 1'b0;
				pad_extra_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_collect: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_COLLECT)
		else $error("ready outside collect");
	a_emit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_words)
		else $error("emit in invalid mode");
	a_pad_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD |-> close_q)
		else $error("pad without close");
`endif

endmodule
`default_nettype wire

// ===== sv/sha512_dpath.sv =====
// Datapath: block buffer, length counter, schedule window and round unit.
`default_nettype none
module sha512_dpath
	import sha512_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] data_byte,
	input  wire cmd_t       cmd,
	input  wire logic       pad_extra,
	output stat_t           stat,
	output word_t           digest_word
);

	logic [6:0]   fill_q;
	logic [127:0] len_q;
	word_t        h_q [0:WORDS-1];
	word_t        v_q [0:WORDS-1];
	word_t        v_nx [0:WORDS-1];
	word_t        w_q [0:15];
	logic [6:0]   round_q;
	logic         busy_q;
	word_t        out_q [0:WORDS-1];

	word_t w_new, w_cur, s0, s1, t1, t2, e, a;

	assign stat.fill = fill_q;
	assign stat.round = round_q;
	assign stat.round_last = busy_q && (round_q == 7'(ROUNDS - 1));
	assign digest_word = out_q[0];

	// Schedule: first 16 words from the block, later from the window
	always_comb begin
		s0 = ror(w_q[1], 1) ^ ror(w_q[1], 8) ^ (w_q[1] >> 7);
		s1 = ror(w_q[14], 19) ^ ror(w_q[14], 61) ^ (w_q[14] >> 6);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (round_q < 7'd16) ? w_q[round_q[3:0]] : w_new;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
			+ (v_q[6] ^ (e & (v_q[5] ^ v_q[6]))) + round_k(round_q) + w_cur;
		t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
			+ ((a & v_q[1]) | (v_q[2] & (a | v_q[1])));
		v_nx[0] = t1 + t2;
		for (int i = 1; i < WORDS; i++) v_nx[i] = v_q[i-1];
		v_nx[4] = v_q[3] + t1;
	end

	// Block words: byte intake, padding fill and schedule shift
	always_ff @(posedge clk) begin
		if (cmd.take_byte) w_q[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] <= data_byte;
		if (cmd.write_pad) begin
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 8; j++) begin
					if (!pad_extra && 8*i+j == int'(fill_q))
						w_q[i][63-8*j -: 8] <= PAD_BYTE;
					else if ((pad_extra || 8*i+j > int'(fill_q)) && 8*i+j < int'(LEN_OFFSET))
						w_q[i][63-8*j -: 8] <= 8'h00;
					else if ((pad_extra || 8*i+j > int'(fill_q)) && fill_q >= 7'(LEN_OFFSET)
						&& !pad_extra) w_q[i][63-8*j -: 8] <= 8'h00;
					else if (8*i+j >= int'(LEN_OFFSET)
						&& (pad_extra || fill_q < 7'(LEN_OFFSET)))
						w_q[i][63-8*j -: 8] <= len_q[8*(127-(8*i+j)) +: 8];
				end
			end
		end
		if (cmd.comp_step && round_q >= 7'd16) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	// Fill count and bit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
		end else if (cmd.restart) begin
			fill_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				fill_q <= fill_q + 7'd1;
				len_q <= len_q + 128'd8;
			end
			if (cmd.write_pad) fill_q <= '0;
		end
	end

	// Round engine and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < WORDS; i++) h_q[i] <= init_value(MODE_512, 3'(i));
		end else begin
			if (cmd.comp_start) begin
				busy_q <= 1'b1;
				round_q <= '0;
				for (int i = 0; i < WORDS; i++) v_q[i] <= h_q[i];
			end else if (cmd.comp_step) begin
				round_q <= round_q + 7'd1;
				for (int i = 0; i < WORDS; i++) v_q[i] <= v_nx[i];
				if (cmd.comp_finish) busy_q <= 1'b0;
			end
			if (cmd.restart)
				for (int i = 0; i < WORDS; i++) h_q[i] <= init_value(mode, 3'(i));
			else if (cmd.comp_finish)
				for (int i = 0; i < WORDS; i++) h_q[i] <= h_q[i] + v_nx[i];
		end
	end

	// Digest output shift register
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			for (int i = 0; i < WORDS; i++) out_q[i] <= h_q[i] + v_nx[i];
		end else if (cmd.emit_next) begin
			for (int i = 0; i < WORDS - 1; i++) out_q[i] <= out_q[i+1];
		end
	end

`ifndef NO_ASSERTIONS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> round_q < 7'(ROUNDS))
		else $error("round out of range");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.take_byte)
		else $error("byte taken during compression");
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.comp_finish |-> busy_q)
		else $error("finish while idle");
`endif

endmodule
`default_nettype wire

// ===== sv/sha512_hash_engine_top.sv =====
// Top level of the streaming SHA-512/SHA-384 hash engine.
// Usage:
//  Input stream s_axis: one item per accepted beat. tdata[7:0] is the
//  message byte, tuser[0] marks it as a real byte, tlast ends the message.
//  Output stream m_axis: digest words, word 0 first; tlast on the last one.
//  Eight words for SHA-512, six for SHA-384, none for the invalid mode.
//  Config: cfg_we with cfg_data[1:0] selects the mode and restarts the
//  message; write only while the engine is idle.
// Throughput: one byte per cycle while a block fills; a full block then
//  holds the input while the single shared round unit compresses it.
//  Message end adds one or two padded blocks, each compressed in turn,
//  then the digest words, one per cycle while m_axis_tready is high.
// Reset: mode SHA-512, initial values loaded, buffer empty, no output.
// Stall: a low m_axis_tready holds the current word; input stays blocked
//  until the digest is fully delivered.
`default_nettype none
module sha512_hash_engine_top
	import sha512_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // data_byte
	input  wire logic        s_axis_tuser,   // byte_valid
	input  wire logic        s_axis_tlast,   // end_of_message
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // digest_word
	output logic             m_axis_tlast    // last_word
);

	logic [1:0] mode_q;
	cmd_t       cmd;
	stat_t      stat;
	logic       pad_extra;

	// Hold digest mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_512;
		else if (cfg_we) mode_q <= cfg_data;
	end

	sha512_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .mode(mode_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte_valid(s_axis_tuser), .in_eom(s_axis_tlast),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
		.out_last(m_axis_tlast), .cmd, .pad_extra, .stat
	);

	sha512_dpath u_dpath (
		.clk, .arst_n, .mode(cfg_we ? cfg_data : mode_q), .data_byte(s_axis_tdata),
		.cmd, .pad_extra, .stat, .digest_word(m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== test/sha512_hash_engine_checker.sv =====
// Checker for the SHA-512/384 engine: digest predictor and output comparison.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine_checker
	import sha512_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [63:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output int               pending_words,
	output int               digests_seen
);

	typedef struct {
		logic [63:0] word;
		logic        last;
	} digest_word_t;

	localparam logic [63:0] K_TAB [0:79] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
	localparam logic [63:0] IV_512 [0:7] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
	localparam logic [63:0] IV_384 [0:7] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
		64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

	mode_t        model_mode;
	logic [63:0]  chain [0:7];
	logic [7:0]   blk [0:127];
	int unsigned  blk_fill;
	logic [127:0] msg_bits;
	digest_word_t digest_fifo [$];

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// Load the start state of the current mode and clear the message.
	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = (model_mode == MODE_512) ? IV_512[i] :
				(model_mode == MODE_384) ? IV_384[i] : 64'd0;
		blk_fill = 0;
		msg_bits = '0;
	endtask

	// Run the 80 rounds on the buffered block and fold into the chain.
	task automatic compress_block();
		logic [63:0] w [0:79];
		logic [63:0] v [0:7];
		logic [63:0] t1, t2;
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 8; j++)
				w[i][63 - 8 * j -: 8] = blk[i * 8 + j];
		for (int i = 16; i < 80; i++)
			w[i] = (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
				+ (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 80; i++) begin
			t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
				+ (v[6] ^ (v[4] & (v[5] ^ v[6]))) + K_TAB[i] + w[i];
			t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
				+ ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	// Absorb one input item; queue digest words on end of message.
	task automatic absorb_item(input logic [7:0] b, input logic is_byte, input logic eom);
		int unsigned i;
		int nwords;
		digest_word_t dw;
		if (is_byte) begin
			msg_bits += 128'd8;
			blk[blk_fill] = b;
			blk_fill++;
			if (blk_fill == 128) begin
				compress_block();
				blk_fill = 0;
			end
		end
		if (eom) begin
			i = blk_fill;
			blk[i] = PAD_BYTE;
			i++;
			if (i > LEN_OFFSET) begin
				while (i < BLOCK_BYTES) begin blk[i] = 8'd0; i++; end
				compress_block();
				i = 0;
			end
			while (i < LEN_OFFSET) begin blk[i] = 8'd0; i++; end
			for (int k = 0; k < 16; k++)
				blk[LEN_OFFSET + k] = msg_bits[127 - 8 * k -: 8];
			compress_block();
			nwords = (model_mode == MODE_512) ? 8 : (model_mode == MODE_384) ? 6 : 0;
			for (int k = 0; k < nwords; k++) begin
				dw.word = chain[k];
				dw.last = (k == nwords - 1);
				digest_fifo.push_back(dw);
			end
			if (nwords > 0) digests_seen++;
			restart_message();
		end
	endtask

	// Track inputs and compare each delivered digest word.
	always @(posedge clk or negedge arst_n) begin
		digest_word_t exp_w;
		if (!arst_n) begin
			model_mode = MODE_512;
			restart_message();
			digest_fifo.delete();
			fail_count = 0;
			digests_seen = 0;
		end else begin
			if (cfg_we) begin
				model_mode = mode_t'(cfg_data);
				restart_message();
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected digest word %h last %b", m_axis_tdata, m_axis_tlast);
				end else begin
					exp_w = digest_fifo.pop_front();
					if (m_axis_tdata !== exp_w.word || m_axis_tlast !== exp_w.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Digest mismatch: expected %h last %b, got %h last %b",
								exp_w.word, exp_w.last, m_axis_tdata, m_axis_tlast);
					end
				end
			end
		end
		pending_words = digest_fifo.size();
	end

endmodule
`default_nettype wire

// ===== test/sha512_hash_engine_top_test.sv =====
// Testbench top: stimulus, idling control and verdict for the hash engine.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine_top_test;
	import sha512_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending_words;
	int          digests_seen;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          items_sent;

	sha512_hash_engine_top dut (.*);
	sha512_hash_engine_checker checker_i (.*);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Randomly stall the receiver at each falling edge.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Send one item, with random idle cycles before it.
	task automatic send_item(input logic [7:0] b, input logic is_byte, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= is_byte;
		s_axis_tlast  <= eom;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Wait until every digest word is out, let the engine settle, then set mode.
	task automatic set_mode(input mode_t m);
		s_axis_tvalid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random message: mostly real bytes, some empty items.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1));
		end
	endtask

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = MODE_512;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b1;
		send_idle_pct = 28;
		recv_idle_pct = 67;
		items_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty message, end without byte, extreme bytes, empty item.
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);
		set_mode(MODE_384);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		set_mode(MODE_BAD);
		send_item(8'h12, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		set_mode(MODE_RSV);
		send_item(8'hff, 1'b1, 1'b1);
		set_mode(MODE_512);
		// Partial message dropped by a mode write.
		send_item(8'h77, 1'b1, 1'b0);
		set_mode(MODE_512);
		send_item(8'h33, 1'b1, 1'b1);

		// Random phases; lengths cross the padding and block boundaries.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
			recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 28 : 0;
			set_mode(mode_t'(ph == 1 ? MODE_384 : MODE_512));
			while (items_sent < 20 + 70 * (ph + 1)) begin
				case ($urandom_range(3))
					0: send_message($urandom_range(1, 8));
					1: send_message($urandom_range(110, 114));
					2: send_message($urandom_range(127, 129));
					default: send_message($urandom_range(9, 60));
				endcase
			end
			// Hold off until all digest words are out.
			s_axis_tvalid <= 1'b0;
			while (pending_words != 0) @(negedge clk);
		end
		set_mode(MODE_BAD);
		send_message(5);

		s_axis_tvalid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("Covered %0d items and %0d digests over SHA-512, SHA-384 and invalid modes,",
			items_sent, digests_seen);
		$display("including padding spill, full-block messages and stalls on both sides.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
